// ----- rtl/core/jsv_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and byte-class helpers for the JSON syntax validator.
// No dependencies.
package jsv_pkg;

  localparam int MAX_DEPTH   = 16;
  localparam int STACK_DEPTH = MAX_DEPTH + 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int BYTE_W    = 8;
  localparam int VERDICT_W = 2;
  localparam int NESTING_W = 5;
  localparam int OUT_W     = 8;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [VERDICT_W-1:0] verdict_t;

  localparam verdict_t VERDICT_PENDING  = 2'd0;
  localparam verdict_t VERDICT_ACCEPTED = 2'd1;
  localparam verdict_t VERDICT_REJECTED = 2'd2;

  localparam logic [1:0] WORD_TRUE  = 2'd0;
  localparam logic [1:0] WORD_FALSE = 2'd1;
  localparam logic [1:0] WORD_NULL  = 2'd2;

  typedef struct packed {
    verdict_t             verdict;
    logic [NESTING_W-1:0] nesting;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

  function automatic logic [2:0] word_len(input logic [1:0] choice);
    logic [2:0] len;
    case (choice)
      WORD_TRUE:  len = 3'd4;
      WORD_FALSE: len = 3'd5;
      WORD_NULL:  len = 3'd4;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] choice, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (choice)
      WORD_TRUE: begin
        case (pos)
          3'd0:    ch = "t";
          3'd1:    ch = "r";
          3'd2:    ch = "u";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      WORD_FALSE: begin
        case (pos)
          3'd0:    ch = "f";
          3'd1:    ch = "a";
          3'd2:    ch = "l";
          3'd3:    ch = "s";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      WORD_NULL: begin
        case (pos)
          3'd0:    ch = "n";
          3'd1:    ch = "u";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/core/json_syntax_validator.sv -----
`timescale 1ns / 1ps
// Channel  | Direction | tdata (low bit up)                  | tlast      | tuser
// in_      | slave     | byte_in[7:0]                         | last_byte  | none
// out_     | master    | verdict[1:0], nesting[6:2], zero pad | none       | none
//
// One request is taken per cycle while in_tready is high; its result is registered.
// The parser state, a 17-entry container stack and a two-entry output buffer set that rate.
// in_tready drops only when both output entries hold results that were not yet taken.
// Reset clears the parser and the buffer; stack entries are never read before written.
// A request flagged last gives the final verdict and returns the parser to reset.
// Top-level JSON syntax validator. Depends on jsv_pkg.
module json_syntax_validator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [jsv_pkg::BYTE_W-1:0] in_tdata,   // byte_in[7:0]
  input  logic                      in_tlast,    // last_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [jsv_pkg::OUT_W-1:0] out_tdata    // verdict[1:0], nesting[6:2], zero[7]
);
  import jsv_pkg::*;

  typedef enum logic [4:0] {
    M_TOP_START, M_OBJ_FIRST, M_OBJ_KEY, M_COLON, M_VALUE, M_ARR_FIRST,
    M_AFTER_VALUE, M_STR, M_STR_ESC, M_STR_HEX, M_NUM_MINUS, M_NUM_ZERO,
    M_NUM_INT, M_NUM_DOT, M_NUM_FRAC, M_NUM_EXP, M_NUM_EXP_SIGN,
    M_NUM_EXP_DIG, M_WORD, M_TRAIL
  } mode_t;

  mode_t      mode_r, mode_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic [2:0] hex_r, hex_nxt;
  logic       name_r, name_nxt;
  logic [2:0] wpos_r, wpos_nxt;
  logic [1:0] wch_r, wch_nxt;
  logic       error_r;
  logic       stack_r [STACK_DEPTH];

  logic       out_valid_r, skid_valid_r;
  result_t    out_data_r, skid_data_r;

  logic       accept, pop;
  logic [7:0] b;
  logic       ok, top_bit, in_range;
  logic       do_vs, do_av, do_push, do_close, push_obj, close_obj;
  logic       push_en;
  logic [IDX_W-1:0] top_idx, push_idx;
  logic [2:0] wpos_inc, hex_inc;
  cnt_t       cnt_dec;
  result_t    result;

  assign b         = in_tdata;
  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;

  assign in_range = (cnt_r != '0) && (cnt_r <= CNT_W'(STACK_DEPTH));
  assign top_idx  = IDX_W'(cnt_r - 1'b1);
  assign push_idx = IDX_W'(cnt_r);
  assign top_bit  = in_range ? stack_r[top_idx] : 1'b0;
  assign cnt_dec  = cnt_r - 1'b1;
  assign wpos_inc = wpos_r + 3'd1;
  assign hex_inc  = hex_r + 3'd1;

  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    hex_nxt   = hex_r;
    name_nxt  = name_r;
    wpos_nxt  = wpos_r;
    wch_nxt   = wch_r;
    ok        = 1'b1;
    do_vs     = 1'b0;
    do_av     = 1'b0;
    do_push   = 1'b0;
    do_close  = 1'b0;
    push_obj  = 1'b0;
    close_obj = 1'b0;
    push_en   = 1'b0;

    case (mode_r)
      M_TOP_START: begin
        if (b == "{") begin
          do_push  = 1'b1;
          push_obj = 1'b1;
        end else if (!is_ws(b)) begin
          ok = 1'b0;
        end
      end
      M_OBJ_FIRST, M_OBJ_KEY: begin
        if (mode_r == M_OBJ_FIRST && b == "}") begin
          do_close  = 1'b1;
          close_obj = 1'b1;
        end else if (b == "\"") begin
          name_nxt = 1'b1;
          mode_nxt = M_STR;
        end else if (!is_ws(b)) begin
          ok = 1'b0;
        end
      end
      M_COLON: begin
        if (b == ":") begin
          mode_nxt = M_VALUE;
        end else if (!is_ws(b)) begin
          ok = 1'b0;
        end
      end
      M_ARR_FIRST, M_VALUE: begin
        if (mode_r == M_ARR_FIRST && b == "]") begin
          do_close = 1'b1;
        end else if (!is_ws(b)) begin
          do_vs = 1'b1;
        end
      end
      M_AFTER_VALUE: do_av = 1'b1;
      M_STR: begin
        if (b < 8'h20) begin
          ok = 1'b0;
        end else if (b == "\"") begin
          mode_nxt = name_r ? M_COLON : M_AFTER_VALUE;
        end else if (b == "\\") begin
          mode_nxt = M_STR_ESC;
        end
      end
      M_STR_ESC: begin
        if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
            b == "n" || b == "r" || b == "t") begin
          mode_nxt = M_STR;
        end else if (b == "u" && !name_r) begin
          hex_nxt  = 3'd0;
          mode_nxt = M_STR_HEX;
        end else begin
          ok = 1'b0;
        end
      end
      M_STR_HEX: begin
        if (!is_hex(b)) begin
          ok = 1'b0;
        end else if (hex_inc >= 3'd4) begin
          hex_nxt  = 3'd0;
          mode_nxt = M_STR;
        end else begin
          hex_nxt = hex_inc;
        end
      end
      M_NUM_MINUS: begin
        if (b == "0") begin
          mode_nxt = M_NUM_ZERO;
        end else if (b >= "1" && b <= "9") begin
          mode_nxt = M_NUM_INT;
        end else begin
          ok = 1'b0;
        end
      end
      M_NUM_ZERO, M_NUM_INT: begin
        if (is_digit(b)) begin
          ok = (mode_r == M_NUM_INT);
        end else if (b == ".") begin
          mode_nxt = M_NUM_DOT;
        end else if (b == "e" || b == "E") begin
          mode_nxt = M_NUM_EXP;
        end else begin
          do_av = 1'b1;
        end
      end
      M_NUM_DOT: begin
        if (is_digit(b)) begin
          mode_nxt = M_NUM_FRAC;
        end else begin
          ok = 1'b0;
        end
      end
      M_NUM_FRAC: begin
        if (b == "e" || b == "E") begin
          mode_nxt = M_NUM_EXP;
        end else if (!is_digit(b)) begin
          do_av = 1'b1;
        end
      end
      M_NUM_EXP, M_NUM_EXP_SIGN: begin
        if (mode_r == M_NUM_EXP && (b == "+" || b == "-")) begin
          mode_nxt = M_NUM_EXP_SIGN;
        end else if (is_digit(b)) begin
          mode_nxt = M_NUM_EXP_DIG;
        end else begin
          ok = 1'b0;
        end
      end
      M_NUM_EXP_DIG: begin
        if (!is_digit(b)) begin
          do_av = 1'b1;
        end
      end
      M_WORD: begin
        if (wch_r > WORD_NULL || wpos_r >= word_len(wch_r)) begin
          ok = 1'b0;
        end else if (b != word_char(wch_r, wpos_r)) begin
          ok = 1'b0;
        end else if (wpos_inc >= word_len(wch_r)) begin
          wpos_nxt = 3'd0;
          mode_nxt = M_AFTER_VALUE;
        end else begin
          wpos_nxt = wpos_inc;
        end
      end
      M_TRAIL: ok = is_ws(b);
      default: ok = 1'b0;
    endcase

    if (do_vs) begin
      if (b == "\"") begin
        name_nxt = 1'b0;
        mode_nxt = M_STR;
      end else if (b == "{") begin
        do_push  = 1'b1;
        push_obj = 1'b1;
      end else if (b == "[") begin
        do_push = 1'b1;
      end else if (b == "t" || b == "f" || b == "n") begin
        wch_nxt  = (b == "t") ? WORD_TRUE : ((b == "f") ? WORD_FALSE : WORD_NULL);
        wpos_nxt = 3'd1;
        mode_nxt = M_WORD;
      end else if (b == "-") begin
        mode_nxt = M_NUM_MINUS;
      end else if (b == "0") begin
        mode_nxt = M_NUM_ZERO;
      end else if (b >= "1" && b <= "9") begin
        mode_nxt = M_NUM_INT;
      end else begin
        ok = 1'b0;
      end
    end

    if (do_av) begin
      mode_nxt = M_AFTER_VALUE;
      if (b == "}") begin
        do_close  = 1'b1;
        close_obj = 1'b1;
      end else if (b == "]") begin
        do_close = 1'b1;
      end else if (b == ",") begin
        if (!in_range) begin
          ok = 1'b0;
        end else begin
          mode_nxt = top_bit ? M_OBJ_KEY : M_VALUE;
        end
      end else if (!is_ws(b)) begin
        ok = 1'b0;
      end
    end

    if (do_push) begin
      if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
        ok = 1'b0;
      end else begin
        push_en  = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        mode_nxt = push_obj ? M_OBJ_FIRST : M_ARR_FIRST;
      end
    end

    if (do_close) begin
      if (!in_range || (top_bit != close_obj)) begin
        ok = 1'b0;
      end else begin
        cnt_nxt  = cnt_dec;
        mode_nxt = (cnt_dec == '0) ? M_TRAIL : M_AFTER_VALUE;
      end
    end

    if (error_r) begin
      ok      = 1'b0;
      cnt_nxt = cnt_r;
      push_en = 1'b0;
    end

    if (!ok) begin
      result.verdict = VERDICT_REJECTED;
    end else if (in_tlast) begin
      result.verdict = (mode_nxt == M_TRAIL) ? VERDICT_ACCEPTED : VERDICT_REJECTED;
    end else begin
      result.verdict = VERDICT_PENDING;
    end
    result.nesting = NESTING_W'(ok ? cnt_nxt : cnt_r);
  end

  always_ff @(posedge clk) begin
    if (accept && push_en) begin
      stack_r[push_idx] <= push_obj;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= M_TOP_START;
      cnt_r        <= '0;
      hex_r        <= 3'd0;
      name_r       <= 1'b0;
      wpos_r       <= 3'd0;
      wch_r        <= 2'd0;
      error_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (in_tlast) begin
          mode_r  <= M_TOP_START;
          cnt_r   <= '0;
          hex_r   <= 3'd0;
          name_r  <= 1'b0;
          wpos_r  <= 3'd0;
          wch_r   <= 2'd0;
          error_r <= 1'b0;
        end else if (!ok) begin
          error_r <= 1'b1;
        end else begin
          mode_r <= mode_nxt;
          cnt_r  <= cnt_nxt;
          hex_r  <= hex_nxt;
          name_r <= name_nxt;
          wpos_r <= wpos_nxt;
          wch_r  <= wch_nxt;
        end
      end

      if (skid_valid_r) begin
        if (pop) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r || pop) begin
          out_data_r  <= result;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= result;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - VERDICT_W - NESTING_W){1'b0}},
                       out_data_r.nesting, out_data_r.verdict};

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("open container count beyond stack depth");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> (cnt_r == '0) && (mode_r == M_TOP_START) && !error_r)
    else $error("parser not returned to start after last byte");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    error_r && !(accept && in_tlast) |=> error_r)
    else $error("error flag cleared before last byte");

  a_trail_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_TRAIL) |-> (cnt_r == '0))
    else $error("trailing mode with containers still open");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for json_syntax_validator: random and hand-picked JSON documents
// are streamed in byte by byte, and every verdict and nesting count is checked against
// a parser kept inside the bench. Depends on jsv_pkg and the validator RTL.
module tb;
  import jsv_pkg::*;

  typedef enum logic [4:0] {
    P_TOP, P_OBJ_FIRST, P_OBJ_KEY, P_COLON, P_VALUE, P_ARR_FIRST, P_AFTER,
    P_STR, P_ESC, P_HEX, P_MINUS, P_ZERO, P_INT, P_DOT, P_FRAC, P_EXP,
    P_EXP_SIGN, P_EXP_DIG, P_WORD, P_TRAIL
  } pmode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic [1:0] ph;
    logic       hold;
  } req_t;

  localparam int BYTE_GOAL = 1850;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;

  req_t       byte_q[$];
  result_t    verdict_due_q[$];
  logic [7:0] doc_q[$];
  req_t       head;
  result_t    due;
  logic       req_done = 1'b0;
  logic [1:0] cur_ph = 2'd0;
  int         err_cnt = 0;

  pmode_t     pmode;
  logic       kinds [STACK_DEPTH];
  int         depth;
  int         hex_cnt;
  int         kw_pos;
  logic [1:0] kw_sel;
  logic       in_name;
  logic       bad;

  json_syntax_validator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_hexd(input logic [7:0] b);
    return is_num(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
  endfunction

  function automatic string kw_text(input logic [1:0] sel);
    case (sel)
      WORD_TRUE:  return "true";
      WORD_FALSE: return "false";
      WORD_NULL:  return "null";
      default:    return "";
    endcase
  endfunction

  function automatic void clear_parser();
    pmode   = P_TOP;
    for (int i = 0; i < STACK_DEPTH; i++) kinds[i] = 1'b0;
    depth   = 0;
    hex_cnt = 0;
    kw_pos  = 0;
    kw_sel  = WORD_TRUE;
    in_name = 1'b0;
    bad     = 1'b0;
  endfunction

  function automatic logic open_box(input logic is_obj);
    if (depth >= STACK_DEPTH) return 1'b0;
    kinds[depth] = is_obj;
    depth++;
    pmode = is_obj ? P_OBJ_FIRST : P_ARR_FIRST;
    return 1'b1;
  endfunction

  function automatic logic shut_box(input logic is_obj);
    if (depth == 0 || depth > STACK_DEPTH) return 1'b0;
    if (kinds[depth-1] != is_obj) return 1'b0;
    depth--;
    pmode = (depth == 0) ? P_TRAIL : P_AFTER;
    return 1'b1;
  endfunction

  function automatic logic start_value(input logic [7:0] b);
    if (b == "\"") begin
      in_name = 1'b0;
      pmode = P_STR;
      return 1'b1;
    end
    if (b == "{") return open_box(1'b1);
    if (b == "[") return open_box(1'b0);
    if (b == "t" || b == "f" || b == "n") begin
      kw_sel = (b == "t") ? WORD_TRUE : (b == "f") ? WORD_FALSE : WORD_NULL;
      kw_pos = 1;
      pmode = P_WORD;
      return 1'b1;
    end
    if (b == "-") begin
      pmode = P_MINUS;
      return 1'b1;
    end
    if (b == "0") begin
      pmode = P_ZERO;
      return 1'b1;
    end
    if (b >= "1" && b <= "9") begin
      pmode = P_INT;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic after_val(input logic [7:0] b);
    pmode = P_AFTER;
    if (is_blank(b)) return 1'b1;
    if (b == "}") return shut_box(1'b1);
    if (b == "]") return shut_box(1'b0);
    if (b == ",") begin
      if (depth == 0 || depth > STACK_DEPTH) return 1'b0;
      pmode = kinds[depth-1] ? P_OBJ_KEY : P_VALUE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic parse_byte(input logic [7:0] b);
    string w;
    case (pmode)
      P_TOP: begin
        if (is_blank(b)) return 1'b1;
        if (b == "{") return open_box(1'b1);
        return 1'b0;
      end
      P_OBJ_FIRST, P_OBJ_KEY: begin
        if (pmode == P_OBJ_FIRST && b == "}") return shut_box(1'b1);
        if (is_blank(b)) return 1'b1;
        if (b == "\"") begin
          in_name = 1'b1;
          pmode = P_STR;
          return 1'b1;
        end
        return 1'b0;
      end
      P_COLON: begin
        if (is_blank(b)) return 1'b1;
        if (b == ":") begin
          pmode = P_VALUE;
          return 1'b1;
        end
        return 1'b0;
      end
      P_ARR_FIRST, P_VALUE: begin
        if (pmode == P_ARR_FIRST && b == "]") return shut_box(1'b0);
        if (is_blank(b)) return 1'b1;
        return start_value(b);
      end
      P_AFTER: return after_val(b);
      P_STR: begin
        if (b < 8'h20) return 1'b0;
        if (b == "\"") begin
          pmode = in_name ? P_COLON : P_AFTER;
          return 1'b1;
        end
        if (b == "\\") pmode = P_ESC;
        return 1'b1;
      end
      P_ESC: begin
        if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
            b == "n" || b == "r" || b == "t") begin
          pmode = P_STR;
          return 1'b1;
        end
        if (b == "u" && !in_name) begin
          hex_cnt = 0;
          pmode = P_HEX;
          return 1'b1;
        end
        return 1'b0;
      end
      P_HEX: begin
        if (!is_hexd(b)) return 1'b0;
        hex_cnt++;
        if (hex_cnt >= 4) begin
          hex_cnt = 0;
          pmode = P_STR;
        end
        return 1'b1;
      end
      P_MINUS: begin
        if (b == "0") begin
          pmode = P_ZERO;
          return 1'b1;
        end
        if (b >= "1" && b <= "9") begin
          pmode = P_INT;
          return 1'b1;
        end
        return 1'b0;
      end
      P_ZERO, P_INT: begin
        if (is_num(b)) return pmode == P_INT;
        if (b == ".") begin
          pmode = P_DOT;
          return 1'b1;
        end
        if (b == "e" || b == "E") begin
          pmode = P_EXP;
          return 1'b1;
        end
        return after_val(b);
      end
      P_DOT: begin
        if (is_num(b)) begin
          pmode = P_FRAC;
          return 1'b1;
        end
        return 1'b0;
      end
      P_FRAC: begin
        if (is_num(b)) return 1'b1;
        if (b == "e" || b == "E") begin
          pmode = P_EXP;
          return 1'b1;
        end
        return after_val(b);
      end
      P_EXP, P_EXP_SIGN: begin
        if (pmode == P_EXP && (b == "+" || b == "-")) begin
          pmode = P_EXP_SIGN;
          return 1'b1;
        end
        if (is_num(b)) begin
          pmode = P_EXP_DIG;
          return 1'b1;
        end
        return 1'b0;
      end
      P_EXP_DIG: begin
        if (is_num(b)) return 1'b1;
        return after_val(b);
      end
      P_WORD: begin
        w = kw_text(kw_sel);
        if (kw_pos >= w.len()) return 1'b0;
        if (b != w[kw_pos]) return 1'b0;
        kw_pos++;
        if (kw_pos >= w.len()) begin
          kw_pos = 0;
          pmode = P_AFTER;
        end
        return 1'b1;
      end
      P_TRAIL: return is_blank(b);
      default: return 1'b0;
    endcase
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (!bad && !parse_byte(b)) bad = 1'b1;
    if (bad) r.verdict = VERDICT_REJECTED;
    else if (last) r.verdict = (pmode == P_TRAIL) ? VERDICT_ACCEPTED : VERDICT_REJECTED;
    else r.verdict = VERDICT_PENDING;
    r.nesting = depth[NESTING_W-1:0];
    verdict_due_q.push_back(r);
    if (last) clear_parser();
  endtask

  task automatic report(input string what, input int got, input int want);
    err_cnt++;
    $display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic add_byte(input logic [7:0] b);
    doc_q.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_ws();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: add_byte(8'h20);
        1: add_byte(8'h09);
        2: add_byte(8'h0A);
        default: add_byte(8'h0D);
      endcase
    end
  endtask

  task automatic add_str(input logic name);
    string esc, hx;
    int r;
    logic [7:0] c;
    esc = "\"\\/bfnrt";
    hx = "0123456789abcdefABCDEF";
    add_byte("\"");
    repeat ($urandom_range(0, 5)) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        add_byte((c == "\"" || c == "\\") ? 8'h71 : c);
      end else if (r == 6) begin
        add_byte(8'($urandom_range(8'h80, 8'hFF)));
      end else if (r == 7 || name) begin
        add_byte("\\");
        add_byte(esc[$urandom_range(0, esc.len() - 1)]);
      end else begin
        add_text("\\u");
        repeat (4) add_byte(hx[$urandom_range(0, hx.len() - 1)]);
      end
    end
    add_byte("\"");
  endtask

  task automatic add_num();
    if ($urandom_range(0, 2) == 0) add_byte("-");
    if ($urandom_range(0, 2) == 0) begin
      add_byte("0");
    end else begin
      add_byte(8'($urandom_range("1", "9")));
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 4) < 2) begin
      add_byte(".");
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 9) < 3) begin
      add_byte($urandom_range(0, 1) ? "e" : "E");
      case ($urandom_range(0, 2))
        0: add_byte("+");
        1: add_byte("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range("0", "9")));
    end
  endtask

  task automatic add_scalar();
    case ($urandom_range(0, 2))
      0: add_str(1'b0);
      1: add_num();
      default: add_text(kw_text(2'($urandom_range(0, 2))));
    endcase
  endtask

  task automatic gen_doc(input int max_lvl);
    logic kind_l[$];
    int   left_l[$];
    int   used_l[$];
    int   t, r;
    logic k;
    add_ws();
    add_byte("{");
    kind_l.push_back(1'b1);
    left_l.push_back($urandom_range(0, 4));
    used_l.push_back(0);
    while (kind_l.size() > 0) begin
      t = kind_l.size() - 1;
      add_ws();
      if (left_l[t] == 0) begin
        add_byte(kind_l[t] ? "}" : "]");
        k = kind_l.pop_back();
        r = left_l.pop_back();
        r = used_l.pop_back();
      end else begin
        if (used_l[t] != 0) begin
          add_byte(",");
          add_ws();
        end
        left_l[t] = left_l[t] - 1;
        used_l[t] = used_l[t] + 1;
        if (kind_l[t]) begin
          add_str(1'b1);
          add_ws();
          add_byte(":");
          add_ws();
        end
        r = $urandom_range(0, 9);
        if (kind_l.size() < max_lvl && r < 3) begin
          k = (r == 0);
          add_byte(k ? "{" : "[");
          kind_l.push_back(k);
          left_l.push_back($urandom_range(0, 3));
          used_l.push_back(0);
        end else begin
          add_scalar();
        end
      end
    end
    add_ws();
  endtask

  // Nests 14 to 17 containers under the top object, one past the limit at most.
  task automatic gen_deep();
    logic kind_l[$];
    add_ws();
    add_text("{\"k\":");
    repeat ($urandom_range(14, 17)) begin
      if ($urandom_range(0, 1)) begin
        add_byte("[");
        kind_l.push_back(1'b0);
      end else begin
        add_text("{\"a\":");
        kind_l.push_back(1'b1);
      end
    end
    add_scalar();
    while (kind_l.size() > 0) add_byte(kind_l.pop_back() ? "}" : "]");
    add_byte("}");
    add_ws();
  endtask

  task automatic damage();
    string odd;
    int r, pos;
    odd = "{}[],:\"\\ 0eE.-+tfnu";
    r = $urandom_range(0, 99);
    pos = $urandom_range(0, doc_q.size() - 1);
    if (r < 10) doc_q[pos] = odd[$urandom_range(0, odd.len() - 1)];
    else if (r < 14) doc_q[pos] = 8'($urandom_range(0, 255));
    else if (r < 16) doc_q[pos] = 8'($urandom_range(0, 31));
    else if (r < 21) doc_q.insert(pos, odd[$urandom_range(0, odd.len() - 1)]);
    else if (r < 26) while (doc_q.size() > pos + 1) doc_q.delete(doc_q.size() - 1);
  endtask

  task automatic commit_doc(input logic [1:0] ph, input logic hold);
    req_t r;
    for (int i = 0; i < doc_q.size(); i++) begin
      r.b    = doc_q[i];
      r.last = (i == doc_q.size() - 1);
      r.ph   = ph;
      r.hold = hold && (i == 0);
      byte_q.push_back(r);
    end
    doc_q.delete();
  endtask

  function automatic int gap_pct(input logic [1:0] ph);
    case (ph)
      2'd1:    return 72;
      2'd3:    return 33;
      default: return 0;
    endcase
  endfunction

  function automatic int stall_pct(input logic [1:0] ph);
    case (ph)
      2'd2:    return 72;
      2'd3:    return 33;
      default: return 0;
    endcase
  endfunction

  initial begin
    int   r;
    logic first;
    clear_parser();
    add_text("{}");
    commit_doc(2'd0, 1'b0);
    add_text("{\"\\u");
    commit_doc(2'd0, 1'b0);
    add_text("{\"\":nx");
    commit_doc(2'd0, 1'b0);
    add_byte(8'hFF);
    commit_doc(2'd0, 1'b0);
    add_text("{\"\":[1,]}");
    commit_doc(2'd0, 1'b0);
    for (int ph = 0; ph < 4; ph++) begin
      first = 1'b1;
      while (byte_q.size() < BYTE_GOAL * (ph + 1) / 4) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
        end else if (r < 12) begin
          gen_deep();
        end else begin
          gen_doc($urandom_range(1, 3));
        end
        damage();
        commit_doc(ph[1:0], first);
        first = 1'b0;
      end
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (byte_q.size() != 0 || in_tvalid || verdict_due_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // The first request of each phase's first document can be held back until all results are back.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || req_done) begin
      if (byte_q.size() != 0 && !(byte_q[0].hold && verdict_due_q.size() != 0) &&
          $urandom_range(0, 99) >= gap_pct(byte_q[0].ph)) begin
        head = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= head.b;
        in_tlast  <= head.last;
        cur_ph    <= head.ph;
      end else begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom_range(0, 255));
        in_tlast  <= 1'($urandom_range(0, 1));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct(cur_ph));
    end
  end

  // Results are checked before this edge's request is predicted.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_due_q.size() == 0) begin
        report("result with nothing outstanding", int'(out_tdata), 0);
      end else begin
        due = verdict_due_q.pop_front();
        if (out_tdata[1:0] !== due.verdict)
          report("verdict", int'(out_tdata[1:0]), int'(due.verdict));
        if (out_tdata[6:2] !== due.nesting)
          report("nesting", int'(out_tdata[6:2]), int'(due.nesting));
      end
    end
    req_done <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
  end

endmodule

// ----- files.f -----
rtl/core/jsv_pkg.sv
rtl/core/json_syntax_validator.sv
tb/sv/tb.sv
